[rtl/deq_pkg.sv]
`default_nettype none

package deq_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = CW + 1;
  localparam int OCC_W = 5;
  localparam int OW    = (CW > OCC_W) ? CW : OCC_W;
  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    logic            wr_en;
    logic            rd_en;
    logic [AW-1:0]   addr;
  } ram_ctrl_t;

endpackage

`default_nettype wire

[rtl/deq_ram.sv]
`default_nettype none

module deq_ram (
  input  wire logic                       clk,
  input  wire deq_pkg::ram_ctrl_t         ctrl,
  input  wire logic [deq_pkg::WORD_W-1:0] wr_data,
  output logic      [deq_pkg::WORD_W-1:0] rd_data
);

  logic [deq_pkg::WORD_W-1:0] mem [deq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data <= mem[ctrl.addr];
    end
  end

endmodule

`default_nettype wire

[rtl/double_ended_queue_core.sv]
`default_nettype none
// Bounded double-ended queue of signed 32-bit words held in a ring memory.
// Input channel in_*: one request word per handshake. in_tuser carries the
// command (push front, push back, pop front, pop back), in_tdata the word to
// push (ignored on pops).
// Output channel out_*: exactly one result word per request, in order.
// out_tdata carries the popped word and the element count after the request,
// out_tuser the status (ok, pop on empty, push on full refused).
// A push or a pop on an empty deque loads its result into the output register
// on acceptance; a pop that reads the memory passes through the slot memory's
// registered read first, then through the output register. Pushes, refused
// pushes and empty pops leave the block ready for the next request; a
// successful pop stops intake until its result is loaded (memory read, then
// load of the output register).
// A request is taken while a finished result waits only if that result is
// taken in the same cycle; a stalled receiver holds the result and stops
// intake. Reset empties the deque (count and front pointer cleared) and
// drops any pending result; slot contents stay undefined until pushed.
module double_ended_queue_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] push_value
  input  wire logic [1:0]  in_tuser,   // [1:0] cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // [31:0] pop_value, [36:32] occupancy, [39:37] zero
  output logic      [1:0]  out_tuser   // [1:0] status
);

  localparam int AW = deq_pkg::AW;
  localparam int CW = deq_pkg::CW;
  localparam int SW = deq_pkg::SW;
  localparam int OW = deq_pkg::OW;

  deq_pkg::state_t   state_r, state_nxt;
  logic [AW-1:0]     front_r, front_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       pop_r, pop_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [4:0]        occ_r, occ_nxt;

  deq_pkg::ram_ctrl_t ram_ctrl;
  logic [31:0]        rd_data;

  logic              accept;
  logic              out_free;
  logic              rd_needed;
  deq_pkg::cmd_t     cmd;
  logic [AW-1:0]     front_dec;
  logic [AW-1:0]     front_inc;
  logic [SW-1:0]     back_sum;
  logic [SW-1:0]     back_wrap;
  logic [CW-1:0]     back_off;
  logic              is_full;
  logic              is_empty;
  logic [OW-1:0]     count_ext;

  assign cmd      = deq_pkg::cmd_t'(in_tuser);
  assign out_free = !out_valid_r || out_tready;
  assign accept   = in_tvalid && in_tready;
  assign is_full  = (count_r == CW'(deq_pkg::DEPTH));
  assign is_empty = (count_r == '0);

  assign front_dec = (front_r == '0) ? AW'(deq_pkg::DEPTH - 1) : front_r - AW'(1);
  assign front_inc = (front_r == AW'(deq_pkg::DEPTH - 1)) ? '0 : front_r + AW'(1);
  assign back_off  = (cmd == deq_pkg::CMD_PUSH_BACK) ? count_r : count_r - CW'(1);
  assign back_sum  = SW'(front_r) + SW'(back_off);
  assign back_wrap = (back_sum >= SW'(deq_pkg::DEPTH)) ?
                     back_sum - SW'(deq_pkg::DEPTH) : back_sum;

  deq_ram u_ram (
    .clk     (clk),
    .ctrl    (ram_ctrl),
    .wr_data (in_tdata),
    .rd_data (rd_data)
  );

  // Request decode and pointer update.
  always_comb begin
    front_nxt     = front_r;
    count_nxt     = count_r;
    ram_ctrl      = '{wr_en: 1'b0, rd_en: 1'b0, addr: front_r};
    status_nxt    = deq_pkg::STAT_OK;
    rd_needed     = 1'b0;
    case (cmd)
      deq_pkg::CMD_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = deq_pkg::STAT_FULL;
        end else begin
          front_nxt      = front_dec;
          count_nxt      = count_r + CW'(1);
          ram_ctrl.wr_en = accept;
          ram_ctrl.addr  = front_dec;
        end
      end
      deq_pkg::CMD_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = deq_pkg::STAT_FULL;
        end else begin
          count_nxt      = count_r + CW'(1);
          ram_ctrl.wr_en = accept;
          ram_ctrl.addr  = back_wrap[AW-1:0];
        end
      end
      deq_pkg::CMD_POP_FRONT: begin
        if (is_empty) begin
          status_nxt = deq_pkg::STAT_EMPTY;
        end else begin
          front_nxt      = front_inc;
          count_nxt      = count_r - CW'(1);
          rd_needed      = 1'b1;
          ram_ctrl.rd_en = accept;
          ram_ctrl.addr  = front_r;
        end
      end
      deq_pkg::CMD_POP_BACK: begin
        if (is_empty) begin
          status_nxt = deq_pkg::STAT_EMPTY;
        end else begin
          count_nxt      = count_r - CW'(1);
          rd_needed      = 1'b1;
          ram_ctrl.rd_en = accept;
          ram_ctrl.addr  = back_wrap[AW-1:0];
        end
      end
      default: begin
        status_nxt = deq_pkg::STAT_OK;
      end
    endcase
  end

  assign count_ext = OW'(count_nxt);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      deq_pkg::S_IDLE: begin
        if (accept && rd_needed) begin
          state_nxt = deq_pkg::S_READ;
        end
      end
      deq_pkg::S_READ: begin
        state_nxt = deq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = deq_pkg::S_IDLE;
      end
    endcase
  end

  // Handshake and output register load.
  always_comb begin
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    pop_nxt       = pop_r;
    case (state_r)
      deq_pkg::S_IDLE: begin
        in_tready = out_free;
        if (accept && !rd_needed) begin
          out_valid_nxt = 1'b1;
          pop_nxt = (status_nxt == deq_pkg::STAT_EMPTY) ? '1 : '0;
        end
      end
      deq_pkg::S_READ: begin
        out_valid_nxt = 1'b1;
        pop_nxt       = rd_data;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
    occ_nxt = accept ? count_ext[4:0] : occ_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= deq_pkg::S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        front_r <= front_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    pop_r <= pop_nxt;
    occ_r <= occ_nxt;
    if (accept) begin
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, occ_r, pop_r};
  assign out_tuser  = status_r;

endmodule

`default_nettype wire

[rtl/double_ended_queue_core_checker.sv]
`default_nettype none

module double_ended_queue_core_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  localparam int OW = deq_pkg::OW;
  localparam logic [OW-1:0] DEPTH_EXT = OW'(deq_pkg::DEPTH);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == deq_pkg::STAT_EMPTY |->
      out_tdata[31:0] == 32'hFFFF_FFFF && out_tdata[36:32] == 5'd0)
    else $error("empty pop result malformed");

  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == deq_pkg::STAT_FULL |->
      out_tdata[31:0] == 32'd0 && out_tdata[36:32] == DEPTH_EXT[4:0])
    else $error("full push result malformed");

  a_no_intake_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !(in_tvalid && in_tready))
    else $error("request taken while result stalled");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind double_ended_queue_core double_ended_queue_core_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [deq_pkg::WORD_W-1:0] pop_value;
    deq_pkg::status_t           status;
    logic [deq_pkg::OCC_W-1:0]  occupancy;
  } deq_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  logic [deq_pkg::WORD_W-1:0] slot_mirror [deq_pkg::DEPTH];
  int                head_slot = 0;
  int                live_count = 0;
  deq_result_t       expected_results [$];
  int                error_count = 0;
  bit                tx_idle_en = 1'b0;
  bit                rx_idle_en = 1'b0;
  int                rx_hold = 0;

  double_ended_queue_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic deque_predict(deq_pkg::cmd_t c, logic [deq_pkg::WORD_W-1:0] v);
    deq_result_t r;
    r.pop_value = '0;
    r.status    = deq_pkg::STAT_OK;
    case (c)
      deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
        if (live_count >= deq_pkg::DEPTH) begin
          r.status = deq_pkg::STAT_FULL;
        end else if (c == deq_pkg::CMD_PUSH_FRONT) begin
          head_slot = (head_slot + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
          slot_mirror[head_slot] = v;
          live_count++;
        end else begin
          slot_mirror[(head_slot + live_count) % deq_pkg::DEPTH] = v;
          live_count++;
        end
      end
      default: begin
        if (live_count == 0) begin
          r.pop_value = '1;
          r.status    = deq_pkg::STAT_EMPTY;
        end else if (c == deq_pkg::CMD_POP_FRONT) begin
          r.pop_value = slot_mirror[head_slot];
          head_slot = (head_slot + 1) % deq_pkg::DEPTH;
          live_count--;
        end else begin
          r.pop_value = slot_mirror[(head_slot + live_count - 1) % deq_pkg::DEPTH];
          live_count--;
        end
      end
    endcase
    r.occupancy = live_count[deq_pkg::OCC_W-1:0];
    expected_results.push_back(r);
  endtask

  task automatic send_request(deq_pkg::cmd_t c, logic [deq_pkg::WORD_W-1:0] v);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tuser  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    deque_predict(c, v);
  endtask

  function automatic deq_pkg::cmd_t pick_cmd(int push_pct);
    if ($urandom_range(0, 99) < push_pct) return deq_pkg::cmd_t'($urandom_range(0, 1));
    return deq_pkg::cmd_t'($urandom_range(2, 3));
  endfunction

  always @(negedge clk) begin
    if (!rx_idle_en) begin
      out_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      rx_hold <= $urandom_range(0, 10);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    deq_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", {out_tuser, out_tdata}, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[31:0] !== want.pop_value)
          report_mismatch("pop_value", out_tdata[31:0], want.pop_value);
        if (out_tdata[36:32] !== want.occupancy)
          report_mismatch("occupancy", out_tdata[36:32], want.occupancy);
        if (out_tdata[39:37] !== 3'b000)
          report_mismatch("tdata pad", out_tdata[39:37], 3'b000);
        if (out_tuser !== want.status)
          report_mismatch("status", out_tuser, want.status);
      end
    end
  end

  task automatic test_empty_pops();
    send_request(deq_pkg::CMD_POP_FRONT, 32'h1234_5678);
    send_request(deq_pkg::CMD_POP_BACK, 32'hFFFF_FFFF);
  endtask

  task automatic test_fill_and_refuse();
    logic [deq_pkg::WORD_W-1:0] edge_words [8];
    edge_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                   32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE};
    for (int i = 0; i < deq_pkg::DEPTH; i++)
      send_request((i % 2) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT,
                   edge_words[i % 8]);
    send_request(deq_pkg::CMD_PUSH_FRONT, 32'hDEAD_BEEF);
    send_request(deq_pkg::CMD_PUSH_BACK, 32'h0BAD_F00D);
    send_request(deq_pkg::CMD_POP_FRONT, 32'h0);
    send_request(deq_pkg::CMD_POP_BACK, 32'h0);
  endtask

  task automatic test_level_sweep();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (int round = 0; round < 12; round++) begin
      repeat (40) send_request(pick_cmd(80), $urandom);
      repeat (40) send_request(pick_cmd(20), $urandom);
    end
  endtask

  task automatic test_random_mix();
    for (int chunk = 0; chunk < 10; chunk++) begin
      tx_idle_en = $urandom_range(0, 1);
      rx_idle_en = $urandom_range(0, 1);
      repeat (50) send_request(pick_cmd(50), $urandom);
    end
  endtask

  task automatic test_back_to_back();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (60) send_request(pick_cmd(75), $urandom);
    repeat (130) send_request(pick_cmd(45), $urandom);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_pops();
    test_fill_and_refuse();
    test_level_sweep();
    test_random_mix();
    test_back_to_back();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
